// ===== design/rbsi_pkg.sv =====
package rbsi_pkg;

    localparam int WORD_BITS = 32;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] ray_origin_x;
        logic signed [WORD_BITS-1:0] ray_origin_y;
        logic signed [WORD_BITS-1:0] ray_origin_z;
        logic signed [WORD_BITS-1:0] ray_dir_x;
        logic signed [WORD_BITS-1:0] ray_dir_y;
        logic signed [WORD_BITS-1:0] ray_dir_z;
        logic signed [WORD_BITS-1:0] box_min_x;
        logic signed [WORD_BITS-1:0] box_min_y;
        logic signed [WORD_BITS-1:0] box_min_z;
        logic signed [WORD_BITS-1:0] box_max_x;
        logic signed [WORD_BITS-1:0] box_max_y;
        logic signed [WORD_BITS-1:0] box_max_z;
    } in_t;

    typedef struct packed {
        logic                        hit;
        logic signed [WORD_BITS-1:0] entry_distance;
        logic signed [WORD_BITS-1:0] exit_distance;
    } out_t;

    typedef struct packed {
        logic parallel;
        logic reject;
    } lane_flag_t;

    localparam logic signed [WORD_BITS-1:0] INT_MAX_W = 32'sh7fffffff;
    localparam logic signed [WORD_BITS-1:0] INT_MIN_W = 32'sh80000000;

endpackage

// ===== design/rbsi_lane.sv =====
module rbsi_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [31:0]           origin,
    input  logic signed [31:0]           dir,
    input  logic signed [31:0]           box_lo,
    input  logic signed [31:0]           box_hi,
    output rbsi_pkg::lane_flag_t         flags,
    output logic signed [32+FRAC_BITS:0] t_lo,
    output logic signed [32+FRAC_BITS:0] t_hi
);
    import rbsi_pkg::*;

    localparam int NW = WORD_BITS + FRAC_BITS;
    localparam int TW = NW + 1;

    logic signed [WORD_BITS:0]   diff [2];
    logic [WORD_BITS-1:0]        nmag [2];
    logic [WORD_BITS-1:0]        dmag;
    lane_flag_t                  flag_in;

    logic [NW-1:0]               dvd_reg [2][NW+1];
    logic [WORD_BITS-1:0]        rem_reg [2][NW+1];
    logic [NW-1:0]               quo_reg [2][NW+1];
    logic                        neg_reg [2][NW+1];
    logic [WORD_BITS-1:0]        dm_reg  [NW+1];
    lane_flag_t                  flag_reg [NW+1];

    logic [WORD_BITS:0]          trial [2][NW+1];
    logic                        ge    [2][NW+1];
    logic signed [TW-1:0]        tq    [2];

    lane_flag_t                  flag_out_reg;
    logic signed [TW-1:0]        t_lo_reg, t_hi_reg;

    always_comb
    begin
        diff[0] = {box_lo[31], box_lo} - {origin[31], origin};
        diff[1] = {box_hi[31], box_hi} - {origin[31], origin};
        for (int k = 0; k < 2; k++)
        begin
            nmag[k] = diff[k][WORD_BITS] ? WORD_BITS'(-diff[k]) : diff[k][WORD_BITS-1:0];
        end
        dmag = dir[31] ? WORD_BITS'(-dir) : dir;
        flag_in.parallel = (dir == '0);
        flag_in.reject   = (dir == '0) && ((origin < box_lo) || (origin > box_hi));
    end

    // one quotient bit per stage, restoring
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            trial[k][0] = '0;
            ge[k][0]    = 1'b0;
            for (int s = 1; s <= NW; s++)
            begin
                trial[k][s] = {rem_reg[k][s-1], dvd_reg[k][s-1][NW-1]};
                ge[k][s]    = trial[k][s] >= {1'b0, dm_reg[s-1]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dm_reg[0]   <= dmag;
            flag_reg[0] <= flag_in;
            for (int k = 0; k < 2; k++)
            begin
                dvd_reg[k][0] <= {nmag[k], {FRAC_BITS{1'b0}}};
                rem_reg[k][0] <= '0;
                quo_reg[k][0] <= '0;
                neg_reg[k][0] <= diff[k][WORD_BITS] ^ dir[31];
            end
            for (int s = 1; s <= NW; s++)
            begin
                dm_reg[s]   <= dm_reg[s-1];
                flag_reg[s] <= flag_reg[s-1];
                for (int k = 0; k < 2; k++)
                begin
                    dvd_reg[k][s] <= dvd_reg[k][s-1] << 1;
                    rem_reg[k][s] <= ge[k][s]
                        ? WORD_BITS'(trial[k][s] - {1'b0, dm_reg[s-1]})
                        : trial[k][s][WORD_BITS-1:0];
                    quo_reg[k][s] <= {quo_reg[k][s-1][NW-2:0], ge[k][s]};
                    neg_reg[k][s] <= neg_reg[k][s-1];
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            tq[k] = neg_reg[k][NW] ? -$signed({1'b0, quo_reg[k][NW]})
                                   :  $signed({1'b0, quo_reg[k][NW]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flag_out_reg <= flag_reg[NW];
            if (tq[0] > tq[1])
            begin
                t_lo_reg <= tq[1];
                t_hi_reg <= tq[0];
            end
            else
            begin
                t_lo_reg <= tq[0];
                t_hi_reg <= tq[1];
            end
        end
    end

    assign flags = flag_out_reg;
    assign t_lo  = t_lo_reg;
    assign t_hi  = t_hi_reg;

endmodule

// ===== design/rbsi_merge.sv =====
module rbsi_merge #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         en,
    input  rbsi_pkg::lane_flag_t         flags [3],
    input  logic signed [32+FRAC_BITS:0] t_lo  [3],
    input  logic signed [32+FRAC_BITS:0] t_hi  [3],
    output rbsi_pkg::out_t               res
);
    import rbsi_pkg::*;

    localparam int TW = WORD_BITS + FRAC_BITS + 1;
    localparam int IW = TW - FRAC_BITS;

    logic signed [TW-1:0] near_next, far_next;
    logic                 bnd_next, rej_next;
    logic signed [TW-1:0] near_reg, far_reg;
    logic                 bnd_reg, rej_reg;

    logic                 miss;
    logic signed [WORD_BITS-1:0] near_int, far_int;

    function automatic logic signed [WORD_BITS-1:0] int_sat(input logic signed [TW-1:0] t);
        logic [TW-1:0] mag;
        logic [IW-1:0] ip;
        logic signed [WORD_BITS-1:0] r;
        mag = t[TW-1] ? TW'(-t) : t;
        ip  = mag[TW-1:FRAC_BITS];
        if (t[TW-1])
            r = (ip >= IW'(33'h80000000)) ? INT_MIN_W : -$signed(ip[WORD_BITS-1:0]);
        else
            r = (ip > IW'(33'h7fffffff)) ? INT_MAX_W : $signed(ip[WORD_BITS-1:0]);
        return r;
    endfunction

    // bounds start unbounded; parallel axes do not narrow
    always_comb
    begin
        near_next = '0;
        far_next  = '0;
        bnd_next  = 1'b0;
        rej_next  = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            rej_next = rej_next | flags[a].reject;
            if (!flags[a].parallel)
            begin
                if (!bnd_next || t_lo[a] > near_next)
                    near_next = t_lo[a];
                if (!bnd_next || t_hi[a] < far_next)
                    far_next = t_hi[a];
                bnd_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            near_reg <= near_next;
            far_reg  <= far_next;
            bnd_reg  <= bnd_next;
            rej_reg  <= rej_next;
        end
    end

    always_comb
    begin
        miss     = rej_reg || (bnd_reg && ((near_reg > far_reg) || far_reg[TW-1]));
        near_int = bnd_reg ? int_sat(near_reg) : INT_MIN_W;
        far_int  = bnd_reg ? int_sat(far_reg)  : INT_MAX_W;
        res.hit            = !miss;
        res.entry_distance = miss ? '0 : near_int;
        res.exit_distance  = miss ? '0 : far_int;
    end

endmodule

// ===== design/ray_box_slab_intersect.sv =====
// Ray against axis-aligned box slab test. One request per cycle is accepted while
// the result side keeps up. Each axis lane registers its operands, runs two
// 32+FRAC_BITS stage bit-per-stage restoring dividers, then an ordering stage,
// followed by a bound merge stage and the output register. A stalled result freezes
// the whole pipeline. Unbounded bounds come out as -2^31 / 2^31-1;
// a miss gives hit = 0 and zero distances.
module ray_box_slab_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ray_valid,
    output logic            ray_ready,
    input  rbsi_pkg::in_t   ray,
    output logic            res_valid,
    input  logic            res_ready,
    output rbsi_pkg::out_t  res
);
    import rbsi_pkg::*;

    localparam int NW    = WORD_BITS + FRAC_BITS;
    localparam int TW    = NW + 1;
    localparam int DEPTH = NW + 3;

    logic                 en;
    logic [DEPTH-1:0]     vld_reg, vld_next;
    logic                 out_valid_reg, out_valid_next;
    out_t                 out_reg;
    out_t                 merged;

    logic signed [31:0]   org [3], dir [3], lo [3], hi [3];
    lane_flag_t           flags [3];
    logic signed [TW-1:0] t_lo [3], t_hi [3];

    assign en        = !out_valid_reg || res_ready;
    assign ray_ready = en;

    assign org = '{ray.ray_origin_x, ray.ray_origin_y, ray.ray_origin_z};
    assign dir = '{ray.ray_dir_x, ray.ray_dir_y, ray.ray_dir_z};
    assign lo  = '{ray.box_min_x, ray.box_min_y, ray.box_min_z};
    assign hi  = '{ray.box_max_x, ray.box_max_y, ray.box_max_z};

    for (genvar a = 0; a < 3; a++)
    begin : g_lane
        rbsi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .clk    (clk),
            .en     (en),
            .origin (org[a]),
            .dir    (dir[a]),
            .box_lo (lo[a]),
            .box_hi (hi[a]),
            .flags  (flags[a]),
            .t_lo   (t_lo[a]),
            .t_hi   (t_hi[a])
        );
    end

    rbsi_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .clk   (clk),
        .en    (en),
        .flags (flags),
        .t_lo  (t_lo),
        .t_hi  (t_hi),
        .res   (merged)
    );

    always_comb
    begin
        vld_next       = {vld_reg[DEPTH-2:0], ray_valid};
        out_valid_next = vld_reg[DEPTH-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= merged;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.hit |-> res.entry_distance == '0 && res.exit_distance == '0)
        else $error("miss with nonzero distances");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.hit |-> res.entry_distance <= res.exit_distance)
        else $error("entry beyond exit on hit");

    a_new_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(vld_reg[DEPTH-1]))
        else $error("result without a request in flight");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(vld_reg))
        else $error("pipeline moved under stall");

endmodule

// ===== tb/sv/ray_box_slab_checker.sv =====
`timescale 1ns / 100ps

module ray_box_slab_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ray_valid,
    input  logic            ray_ready,
    input  rbsi_pkg::in_t   ray,
    input  logic            res_valid,
    input  logic            res_ready,
    input  rbsi_pkg::out_t  res,
    output int              fail_count,
    output int              pending,
    output int              hits_seen,
    output int              results_seen
);
    import rbsi_pkg::*;

    out_t expected_hits[$];

    function automatic logic signed [63:0] plane_param(logic signed [63:0] num,
                                                       logic signed [63:0] den);
        logic        neg;
        logic [63:0] nm;
        logic [63:0] dm;
        logic [63:0] q;
        neg = (num < 0) != (den < 0);
        nm = (num < 0) ? -num : num;
        dm = (den < 0) ? -den : den;
        q = (nm << FRAC_BITS) / dm;
        return neg ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [31:0] whole_distance(logic signed [63:0] t);
        logic [63:0]        mag;
        logic signed [63:0] ip;
        mag = (t < 0) ? -t : t;
        ip = $signed(mag >> FRAC_BITS);
        if (t < 0)
            ip = -ip;
        if (ip > 64'sd2147483647)
            ip = 64'sd2147483647;
        if (ip < -64'sd2147483648)
            ip = -64'sd2147483648;
        return ip[31:0];
    endfunction

    function automatic out_t slab_test(in_t r);
        logic signed [31:0] org[3];
        logic signed [31:0] dir[3];
        logic signed [31:0] lo[3];
        logic signed [31:0] hi[3];
        logic signed [63:0] tnear;
        logic signed [63:0] tfar;
        logic signed [63:0] t1;
        logic signed [63:0] t2;
        logic signed [63:0] tmp;
        logic               ok;
        out_t               o;
        org = '{r.ray_origin_x, r.ray_origin_y, r.ray_origin_z};
        dir = '{r.ray_dir_x, r.ray_dir_y, r.ray_dir_z};
        lo = '{r.box_min_x, r.box_min_y, r.box_min_z};
        hi = '{r.box_max_x, r.box_max_y, r.box_max_z};
        tnear = -(64'sd1 <<< 62);
        tfar = 64'sd1 <<< 62;
        ok = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if (!ok)
                continue;
            if (dir[a] == 0)
            begin
                if (org[a] < lo[a] || org[a] > hi[a])
                    ok = 1'b0;
            end
            else
            begin
                t1 = plane_param(64'(lo[a]) - 64'(org[a]), 64'(dir[a]));
                t2 = plane_param(64'(hi[a]) - 64'(org[a]), 64'(dir[a]));
                if (t1 > t2)
                begin
                    tmp = t1;
                    t1 = t2;
                    t2 = tmp;
                end
                if (t1 > tnear)
                    tnear = t1;
                if (t2 < tfar)
                    tfar = t2;
                if (tnear > tfar || tfar < 0)
                    ok = 1'b0;
            end
        end
        o = '0;
        if (ok)
        begin
            o.hit = 1'b1;
            o.entry_distance = whole_distance(tnear);
            o.exit_distance = whole_distance(tfar);
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending <= 0;
            hits_seen <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (ray_valid && ray_ready)
                expected_hits.push_back(slab_test(ray));
            if (res_valid && res_ready)
            begin
                results_seen <= results_seen + 1;
                if (res.hit)
                    hits_seen <= hits_seen + 1;
                if (expected_hits.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %p", res);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (res !== want)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p got %p", want, res);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_hits.size();
        end
    end
endmodule

// ===== tb/sv/ray_box_slab_intersect_test.sv =====
`timescale 1ns / 100ps

module ray_box_slab_intersect_test;
    import rbsi_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic ray_valid = 1'b0;
    logic ray_ready;
    in_t  ray = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    out_t res;
    int   fail_count;
    int   pending;
    int   hits_seen;
    int   results_seen;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    always #4 clk = ~clk;

    ray_box_slab_intersect dut (
        .clk(clk), .rst_n(rst_n), .ray_valid(ray_valid), .ray_ready(ray_ready),
        .ray(ray), .res_valid(res_valid), .res_ready(res_ready), .res(res)
    );

    ray_box_slab_checker chk (
        .clk(clk), .rst_n(rst_n), .ray_valid(ray_valid), .ray_ready(ray_ready),
        .ray(ray), .res_valid(res_valid), .res_ready(res_ready), .res(res),
        .fail_count(fail_count), .pending(pending), .hits_seen(hits_seen),
        .results_seen(results_seen)
    );

    always @(posedge clk)
        res_ready <= ($urandom_range(99) >= recv_stall_pct);

    function automatic logic [31:0] any_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return $urandom_range(1) ? 32'hffff_ffff : 32'h1;
            default: return $urandom;
        endcase
    endfunction

    // small Q16.16 value, some with fractions
    function automatic logic [31:0] near_word(int span);
        logic signed [31:0] v;
        v = $signed($urandom_range(2 * span)) - span;
        return (v <<< 16) + $signed($urandom_range(1) ? 32'(($urandom & 16'hffff)) : 32'd0);
    endfunction

    // valid stays high into the next request unless the sender goes idle
    task automatic send_request(in_t r);
        ray <= r;
        ray_valid <= 1'b1;
        @(posedge clk);
        while (!ray_ready)
            @(posedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            ray_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
    endtask

    function automatic in_t scene_ray();
        in_t r;
        logic [31:0] a;
        logic [31:0] b;
        r.ray_origin_x = near_word(200);
        r.ray_origin_y = near_word(200);
        r.ray_origin_z = near_word(200);
        r.ray_dir_x = ($urandom_range(7) == 0) ? 32'h0 : near_word(4);
        r.ray_dir_y = ($urandom_range(7) == 0) ? 32'h0 : near_word(4);
        r.ray_dir_z = ($urandom_range(7) == 0) ? 32'h0 : near_word(4);
        a = near_word(100); b = near_word(100);
        r.box_min_x = ($signed(a) < $signed(b)) ? a : b;
        r.box_max_x = ($signed(a) < $signed(b)) ? b : a;
        a = near_word(100); b = near_word(100);
        r.box_min_y = ($signed(a) < $signed(b)) ? a : b;
        r.box_max_y = ($signed(a) < $signed(b)) ? b : a;
        a = near_word(100); b = near_word(100);
        r.box_min_z = ($signed(a) < $signed(b)) ? a : b;
        r.box_max_z = ($signed(a) < $signed(b)) ? b : a;
        // aim at the box center now and then so hits are common
        if ($urandom_range(1))
        begin
            r.ray_dir_x = (($signed(r.box_min_x) >>> 1) + ($signed(r.box_max_x) >>> 1)
                           - $signed(r.ray_origin_x)) >>> 6;
            r.ray_dir_y = (($signed(r.box_min_y) >>> 1) + ($signed(r.box_max_y) >>> 1)
                           - $signed(r.ray_origin_y)) >>> 6;
            r.ray_dir_z = (($signed(r.box_min_z) >>> 1) + ($signed(r.box_max_z) >>> 1)
                           - $signed(r.ray_origin_z)) >>> 6;
        end
        return r;
    endfunction

    function automatic in_t noise_ray();
        in_t r;
        r = {any_word(), any_word(), any_word(), any_word(), any_word(), any_word(),
             any_word(), any_word(), any_word(), any_word(), any_word(), any_word()};
        return r;
    endfunction

    task automatic directed_requests();
        in_t r;
        // all parallel, origin inside: unbounded bounds
        r = '0;
        r.box_min_x = -32'sd65536; r.box_min_y = -32'sd65536; r.box_min_z = -32'sd65536;
        r.box_max_x = 32'sd65536; r.box_max_y = 32'sd65536; r.box_max_z = 32'sd65536;
        send_request(r);
        // parallel and outside on each axis
        r.ray_origin_x = 32'sh0002_0000; send_request(r);
        r.ray_origin_x = 0; r.ray_origin_y = -32'sh0002_0000; send_request(r);
        r.ray_origin_y = 0; r.ray_origin_z = 32'sh7fff_ffff; send_request(r);
        // swapped corners on a parallel axis
        r.ray_origin_z = 0; r.box_min_x = 32'sh0001_0000; r.box_max_x = -32'sh0001_0000;
        send_request(r);
        // swapped corners on a moving axis
        r.ray_dir_x = 32'sh0001_0000; send_request(r);
        // ray along +x from far left, box ahead
        r = '0;
        r.ray_origin_x = -32'sh000a_0000; r.ray_dir_x = 32'sh0001_0000;
        r.box_min_x = -32'sh0001_0000; r.box_max_x = 32'sh0001_0000;
        r.box_min_y = -32'sh0001_0000; r.box_max_y = 32'sh0001_0000;
        r.box_min_z = -32'sh0001_0000; r.box_max_z = 32'sh0001_0000;
        send_request(r);
        // box behind: far < 0
        r.ray_dir_x = -32'sh0001_0000; send_request(r);
        // near exactly zero, then near equal far (flat box)
        r.ray_origin_x = 32'sh0001_0000; send_request(r);
        r.ray_dir_x = 32'sh0001_0000; r.ray_origin_x = 0; r.box_min_x = 32'sh0003_0000;
        r.box_max_x = 32'sh0003_0000; send_request(r);
        // tiny direction, huge span: saturation both ways
        r = '0;
        r.ray_origin_x = 32'sh8000_0000; r.ray_dir_x = 32'sd1;
        r.box_min_x = 32'sh8000_0000; r.box_max_x = 32'sh7fff_ffff;
        r.box_min_y = 32'sh8000_0000; r.box_max_y = 32'sh7fff_ffff;
        r.box_min_z = 32'sh8000_0000; r.box_max_z = 32'sh7fff_ffff;
        send_request(r);
        r.ray_dir_x = -32'sd1; r.ray_origin_x = 32'sh7fff_ffff; send_request(r);
        r.ray_dir_x = 32'sh8000_0000; send_request(r);
        r.ray_dir_x = 32'sh7fff_ffff; r.ray_origin_x = 0; send_request(r);
        // negative entry, all three axes moving
        r = '0;
        r.ray_dir_x = 32'sh0001_8000; r.ray_dir_y = -32'sh0000_4000; r.ray_dir_z = 32'sd3;
        r.box_min_x = -32'sh0010_0000; r.box_max_x = 32'sh0010_0000;
        r.box_min_y = -32'sh0010_0000; r.box_max_y = 32'sh0010_0000;
        r.box_min_z = -32'sh0010_0000; r.box_max_z = 32'sh0010_0000;
        send_request(r);
        // extremes everywhere
        send_request({12{32'h8000_0000}});
        send_request({12{32'h7fff_ffff}});
        send_request({12{32'hffff_ffff}});
        send_request({12{32'h5555_5555}});
        send_request({12{32'haaaa_aaaa}});
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_requests();
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                3: begin send_idle_pct = 32; recv_stall_pct = 32; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int i = 0; i < 200; i++)
                send_request(($urandom_range(99) < 75) ? scene_ray() : noise_ray());
        end
        ray_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("%0d results checked, %0d hits, across five idle and stall mixes",
                 results_seen, hits_seen);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
